/* sv/adc_pkg.sv */
// Shared constants, types and the coverage lookup table for the disc coverage block.
package adc_pkg;

    localparam int SUB          = 5;
    localparam int SUB_AREA     = 25;
    localparam int FULL         = 255;
    localparam int RADIUS_INSET = 2;

    localparam int COORD_W     = 10;
    localparam int SIZE_REG_W  = 11;
    localparam int COV_W       = 8;
    localparam int CNT_W       = 5;
    localparam int ROW_W       = 3;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 8;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [SIZE_REG_W-1:0] SIZE_RESET       = 11'd16;
    localparam logic [APB_ADDR_W-1:0] ADDR_CIRCLE_SIZE = 2'd0;

    typedef logic [COV_W-1:0] cov_lut_t [0:SUB_AREA];

    // count * 255 / 25, truncated, for every possible count
    function automatic cov_lut_t build_cov_lut();
        cov_lut_t lut;
        for (int n = 0; n <= SUB_AREA; n++)
        begin
            lut[n] = COV_W'((n * FULL) / SUB_AREA);
        end
        return lut;
    endfunction

    localparam cov_lut_t COV_LUT = build_cov_lut();

endpackage

/* sv/adc_cfg.sv */
// Configuration register file: circle size plus the derived centre and squared radius.
module adc_cfg #(
    parameter int MAX_SIZE = 1024,
    parameter int CT_W     = 12,
    parameter int RR_W     = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [adc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [adc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [adc_pkg::APB_DATA_W-1:0]    prdata,
    output logic [CT_W-1:0]                   ct,
    output logic [RR_W-1:0]                   rr
);

    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
    localparam int S5_W     = SIZE_W + 3;
    localparam int S_RESET  = (int'(adc_pkg::SIZE_RESET) > MAX_SIZE) ?
                              MAX_SIZE : int'(adc_pkg::SIZE_RESET);
    localparam int CT_RESET = (S_RESET * adc_pkg::SUB) / 2;
    localparam int R_RESET  = CT_RESET - adc_pkg::RADIUS_INSET;
    localparam int RR_RESET = R_RESET * R_RESET;

    logic [adc_pkg::SIZE_REG_W-1:0] circle_size_reg;
    logic [adc_pkg::SIZE_REG_W-1:0] circle_size_next;
    logic [CT_W-1:0]                ct_reg;
    logic [CT_W-1:0]                ct_next;
    logic [RR_W-1:0]                rr_reg;
    logic [RR_W-1:0]                rr_next;
    logic                           write_en;
    logic [SIZE_W-1:0]              size_eff;
    logic [S5_W-1:0]                size_x5;
    logic [CT_W-1:0]                radius;

    assign write_en = psel & penable & pwrite & (paddr == adc_pkg::ADDR_CIRCLE_SIZE);

    // Derive centre and radius from the value being written so both land together.
    always_comb
    begin
        circle_size_next = write_en ? pwdata[adc_pkg::SIZE_REG_W-1:0] : circle_size_reg;
        if (circle_size_next == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (32'(circle_size_next) > MAX_SIZE)
        begin
            size_eff = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            size_eff = SIZE_W'(circle_size_next);
        end
        size_x5 = (S5_W'(size_eff) << 2) + S5_W'(size_eff);
        ct_next = CT_W'(size_x5 >> 1);
        radius  = ct_next - CT_W'(adc_pkg::RADIUS_INSET);
        rr_next = RR_W'(radius) * RR_W'(radius);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circle_size_reg <= adc_pkg::SIZE_RESET;
            ct_reg          <= CT_W'(CT_RESET);
            rr_reg          <= RR_W'(RR_RESET);
        end
        else
        begin
            circle_size_reg <= circle_size_next;
            ct_reg          <= ct_next;
            rr_reg          <= rr_next;
        end
    end

    assign prdata = (paddr == adc_pkg::ADDR_CIRCLE_SIZE) ?
                    adc_pkg::APB_DATA_W'(circle_size_reg) : '0;
    assign ct     = ct_reg;
    assign rr     = rr_reg;

endmodule

/* sv/adc_offset_sq.sv */
// Offset of a pixel coordinate from the disc centre in subsample units, and its square.
module adc_offset_sq #(
    parameter int CT_W  = 12,
    parameter int OFF_W = 14
) (
    input  logic [adc_pkg::COORD_W-1:0] coord,
    input  logic [CT_W-1:0]             ct,
    output logic signed [OFF_W-1:0]     off,
    output logic signed [2*OFF_W-1:0]   off_sq
);

    logic signed [OFF_W-1:0] coord_x5;
    logic signed [OFF_W-1:0] ct_s;

    always_comb
    begin
        coord_x5 = $signed((OFF_W'(coord) << 2) + OFF_W'(coord));
        ct_s     = $signed(OFF_W'(ct));
        off      = coord_x5 - ct_s;
        off_sq   = off * off;
    end

endmodule

/* sv/adc_count.sv */
// Inside test of the 5x5 subsample grid; one count of inside samples per subsample row.
module adc_count #(
    parameter int OFF_W = 14,
    parameter int RR_W  = 24
) (
    input  logic signed [OFF_W-1:0]                          ax,
    input  logic signed [2*OFF_W-1:0]                        ax2,
    input  logic signed [OFF_W-1:0]                          ay,
    input  logic signed [2*OFF_W-1:0]                        ay2,
    input  logic [RR_W-1:0]                                  rr,
    output logic [adc_pkg::SUB-1:0][adc_pkg::ROW_W-1:0]      row_cnt
);

    localparam int SUM_W = 2 * OFF_W + 2;

    logic signed [SUM_W-1:0] sx [adc_pkg::SUB];
    logic signed [SUM_W-1:0] sy [adc_pkg::SUB];
    logic signed [SUM_W-1:0] rr_s;

    // (a + j)^2 = a^2 + 2ja + j^2: the per-offset squares need only shifts and adds
    always_comb
    begin
        rr_s = $signed(SUM_W'(rr));
        for (int k = 0; k < adc_pkg::SUB; k++)
        begin
            sx[k] = SUM_W'(ax2) + SUM_W'(ax) * SUM_W'(2 * k) + SUM_W'(k * k);
            sy[k] = SUM_W'(ay2) + SUM_W'(ay) * SUM_W'(2 * k) + SUM_W'(k * k);
        end
        for (int j = 0; j < adc_pkg::SUB; j++)
        begin
            row_cnt[j] = '0;
            for (int k = 0; k < adc_pkg::SUB; k++)
            begin
                if (sx[k] + sy[j] < rr_s)
                begin
                    row_cnt[j] = row_cnt[j] + adc_pkg::ROW_W'(1);
                end
            end
        end
    end

endmodule

/* sv/antialiased_disc_coverage.sv */
// Top level: four-stage pipeline computing 5x5 supersampled disc coverage per pixel.
// A pixel passes through 4 register stages, stage 0 to stage 3, before its result is valid.
// Throughput: one pixel per cycle while the output is not stalled; each stage holds one item.
// A stalled output holds its result; earlier stages keep taking items until all are full,
// then the input is held off until the output drains.
// Reset (rst_n low, asynchronous): empties every stage and sets circle_size to 16.
module antialiased_disc_coverage #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [adc_pkg::TDATA_IN_W-1:0]    s_axis_tdata,   // [9:0] pixel_x, [19:10] pixel_y
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [adc_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,   // [7:0] coverage
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [adc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [adc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [adc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CT_W  = $clog2((MAX_SIZE * adc_pkg::SUB) / 2 + 1);
    localparam int RR_W  = 2 * CT_W;
    localparam int PX5_W = adc_pkg::COORD_W + 3;
    localparam int OFF_W = ((PX5_W > CT_W) ? PX5_W : CT_W) + 1;

    localparam int CW  = adc_pkg::COORD_W;
    localparam int SUB = adc_pkg::SUB;
    localparam int RW  = adc_pkg::ROW_W;

    // configuration and derived geometry
    logic [CT_W-1:0] ct;
    logic [RR_W-1:0] rr;

    // stage 0: captured pixel coordinates
    logic          v0_reg, v0_next;
    logic [CW-1:0] px_reg, px_next;
    logic [CW-1:0] py_reg, py_next;

    // stage 1: centre offsets and their squares
    logic                     v1_reg, v1_next;
    logic signed [OFF_W-1:0]   ax_reg, ax_next;
    logic signed [OFF_W-1:0]   ay_reg, ay_next;
    logic signed [2*OFF_W-1:0] ax2_reg, ax2_next;
    logic signed [2*OFF_W-1:0] ay2_reg, ay2_next;

    // stage 2: inside count of each subsample row
    logic                     v2_reg, v2_next;
    logic [SUB-1:0][RW-1:0]   row_cnt_reg, row_cnt_next;

    // stage 3: result
    logic                              v3_reg, v3_next;
    logic [adc_pkg::COV_W-1:0]         cov_reg, cov_next;

    logic rdy0, rdy1, rdy2, rdy3;
    logic [adc_pkg::CNT_W-1:0] total;

    adc_cfg #(
        .MAX_SIZE (MAX_SIZE),
        .CT_W     (CT_W),
        .RR_W     (RR_W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .ct      (ct),
        .rr      (rr)
    );

    adc_offset_sq #(
        .CT_W  (CT_W),
        .OFF_W (OFF_W)
    ) u_offset_x (
        .coord  (px_reg),
        .ct     (ct),
        .off    (ax_next),
        .off_sq (ax2_next)
    );

    adc_offset_sq #(
        .CT_W  (CT_W),
        .OFF_W (OFF_W)
    ) u_offset_y (
        .coord  (py_reg),
        .ct     (ct),
        .off    (ay_next),
        .off_sq (ay2_next)
    );

    adc_count #(
        .OFF_W (OFF_W),
        .RR_W  (RR_W)
    ) u_count (
        .ax      (ax_reg),
        .ax2     (ax2_reg),
        .ay      (ay_reg),
        .ay2     (ay2_reg),
        .rr      (rr),
        .row_cnt (row_cnt_next)
    );

    // A stage may advance when it is empty or the stage after it advances.
    always_comb
    begin
        rdy3 = !v3_reg || m_axis_tready;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        rdy0 = !v0_reg || rdy1;
    end

    // Sum the row counts and map the sample count to an 8-bit coverage.
    always_comb
    begin
        total = '0;
        for (int j = 0; j < SUB; j++)
        begin
            total = total + adc_pkg::CNT_W'(row_cnt_reg[j]);
        end
        cov_next = adc_pkg::COV_LUT[total];
    end

    always_comb
    begin
        v0_next = rdy0 ? s_axis_tvalid : v0_reg;
        v1_next = rdy1 ? v0_reg : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;

        // load a pixel on acceptance, hold otherwise
        px_next = (rdy0 && s_axis_tvalid) ? s_axis_tdata[CW-1:0]    : px_reg;
        py_next = (rdy0 && s_axis_tvalid) ? s_axis_tdata[2*CW-1:CW] : py_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // payload: advance a stage only when it takes a valid item from the one before
    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        if (rdy1 && v0_reg)
        begin
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            ax2_reg <= ax2_next;
            ay2_reg <= ay2_next;
        end
        if (rdy2 && v1_reg)
        begin
            row_cnt_reg <= row_cnt_next;
        end
        if (rdy3 && v2_reg)
        begin
            cov_reg <= cov_next;
        end
    end

    assign s_axis_tready = rdy0;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = cov_reg;
    assign pready        = 1'b1;

endmodule

/* sv/adc_checker.sv */
// Port-level checker for the disc coverage block, bound to the top level.
module adc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [adc_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [adc_pkg::APB_ADDR_W-1:0]    paddr,
    input logic [adc_pkg::APB_DATA_W-1:0]    pwdata,
    input logic [adc_pkg::APB_DATA_W-1:0]    prdata,
    input logic                              pready
);

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

    // With the output stage empty the whole pipeline drains, so input is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output is empty");

    // A written circle size reads back, truncated to the register width.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == adc_pkg::ADDR_CIRCLE_SIZE)
        ##1 (paddr == adc_pkg::ADDR_CIRCLE_SIZE)
        |-> prdata == adc_pkg::APB_DATA_W'($past(pwdata[adc_pkg::SIZE_REG_W-1:0])))
    else $error("circle size readback mismatch");

    // Reset empties the output stage.
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind antialiased_disc_coverage adc_checker u_adc_checker (.*);
